/* rtl/dwsp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwsp_pkg: shared definitions for the dual wheel speed controller
// Widths, register indexes and the request type of the shared multiplier.
// ----------------------------------------------------------------------------
package dwsp_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int TICK_W     = 6;
    localparam int MUL_A_W    = 33;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int OUT_CNT_W  = 12;
    localparam int POWER_W    = 10;
    localparam int ERR_W      = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P        = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I        = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_ZONE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_CAP  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_POWER     = 8'd6;

    typedef struct packed {
        logic                      en;
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage
`default_nettype wire

/* rtl/dwsp_edge.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwsp_edge: rising edge counter for one encoder line
// Counts 0-to-1 transitions of the sampled level, saturating at all ones.
// ----------------------------------------------------------------------------
module dwsp_edge #(
    parameter int COUNT_WIDTH = 12
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_level,
    input  wire logic                   i_clear,
    output logic [COUNT_WIDTH-1:0]      o_count
);

    logic                   r_prev;
    logic                   n_prev;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;

    always_comb begin
        n_prev  = r_prev;
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (i_en) begin
            n_prev = i_level;
            if (i_level && !r_prev && !(&r_count)) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 1'b0;
            r_count <= '0;
        end else begin
            r_prev  <= n_prev;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule
`default_nettype wire

/* rtl/dwsp_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dwsp_mul: shared signed multiplier
// One signed multiply per enabled cycle, product registered.
// ----------------------------------------------------------------------------
module dwsp_mul (
    input  wire logic                                i_clk,
    input  wire dwsp_pkg::t_mul_req                  i_req,
    output logic signed [dwsp_pkg::PROD_W-1:0]       o_prod
);
    import dwsp_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

/* rtl/dual_wheel_speed_pid.sv */
// A tick that does not close the window leaves the block ready for the next tick.
// A window-closing tick keeps the block busy for nine sequencer steps per wheel
// on the one shared multiplier plus one step to load the result register, longer if the
// previous result is still waiting. Throughput: one tick per cycle, but none while busy.
// Reset: synchronous, active low; clears all loop state and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_wheel_speed_pid: two incremental PID speed loops sharing one multiplier
// Counts encoder edges per wheel over a fixed window of ticks, then updates
// each wheel's drive power from its speed error.
// ----------------------------------------------------------------------------
module dual_wheel_speed_pid #(
    parameter int WINDOW_TICKS    = 50,
    parameter int SPEED_PER_COUNT = 71,
    parameter int COUNT_WIDTH     = 12
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Tick input channel.
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic                                  i_enc_right,
    input  wire logic                                  i_enc_left,
    // Result channel.
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic [dwsp_pkg::POWER_W-1:0]               o_power_left,
    output logic [dwsp_pkg::POWER_W-1:0]               o_power_right,
    output logic [dwsp_pkg::OUT_CNT_W-1:0]             o_count_left,
    output logic [dwsp_pkg::OUT_CNT_W-1:0]             o_count_right,
    output logic signed [dwsp_pkg::ERR_W-1:0]          o_error_left,
    output logic signed [dwsp_pkg::ERR_W-1:0]          o_error_right,
    // Configuration write channel.
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [dwsp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [dwsp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import dwsp_pkg::*;

    // Sequencer steps. Each wheel walks SPEED through PWR once.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SPEED = 4'd1;  // count times speed scale
    localparam logic [3:0] S_ERR   = 4'd2;  // saturated error and derivative
    localparam logic [3:0] S_SUM   = 4'd3;  // integral update and cap
    localparam logic [3:0] S_MP    = 4'd4;  // error times gain_p
    localparam logic [3:0] S_MI    = 4'd5;  // sum times gain_i
    localparam logic [3:0] S_MD    = 4'd6;  // difference times gain_d
    localparam logic [3:0] S_ADD   = 4'd7;  // last product into the total
    localparam logic [3:0] S_TRUNC = 4'd8;  // Q16.16 total to integer, toward zero
    localparam logic [3:0] S_PWR   = 4'd9;  // accumulate and clamp the power
    localparam logic [3:0] S_DONE  = 4'd10; // load the result register

    localparam int CEXT_W = (COUNT_WIDTH > OUT_CNT_W) ? COUNT_WIDTH : OUT_CNT_W;
    localparam logic [TICK_W-1:0] WINDOW_END = TICK_W'(WINDOW_TICKS);

    // Control and loop state.
    logic [3:0]                r_state, n_state;
    logic                      r_wheel, n_wheel;
    logic [TICK_W-1:0]         r_tick, n_tick;
    logic signed [31:0]        r_sum  [2];
    logic signed [31:0]        n_sum  [2];
    logic signed [ERR_W-1:0]   r_last [2];
    logic signed [ERR_W-1:0]   n_last [2];
    logic [POWER_W-1:0]        r_pwr  [2];
    logic [POWER_W-1:0]        n_pwr  [2];
    logic                      r_out_valid, n_out_valid;

    // Configuration registers.
    logic [14:0]               r_target, n_target;
    logic [15:0]               r_gain_p, n_gain_p;
    logic [15:0]               r_gain_i, n_gain_i;
    logic [15:0]               r_gain_d, n_gain_d;
    logic signed [15:0]        r_zone, n_zone;
    logic [30:0]               r_cap, n_cap;
    logic [POWER_W-1:0]        r_max, n_max;

    // Working registers of the current wheel.
    logic signed [ERR_W-1:0]   r_err, n_err;
    logic signed [ERR_W:0]     r_diff, n_diff;
    logic signed [PROD_W-1:0]  r_acc, n_acc;
    logic signed [33:0]        r_quo, n_quo;

    // Result register.
    logic [POWER_W-1:0]        r_out_pwr_l, r_out_pwr_r;
    logic [OUT_CNT_W-1:0]      r_out_cnt_l, r_out_cnt_r;
    logic signed [ERR_W-1:0]   r_out_err_l, r_out_err_r;

    logic                      accept;
    logic                      close;
    logic                      load;
    logic [TICK_W-1:0]         tick_next;
    logic [COUNT_WIDTH-1:0]    cnt_l, cnt_r, cnt_sel;
    logic [CEXT_W-1:0]         cnt_l_ext, cnt_r_ext;
    t_mul_req                  mul_req;
    logic signed [PROD_W-1:0]  prod;

    logic signed [33:0]        spd_err;
    logic signed [ERR_W-1:0]   err_sat;
    logic signed [32:0]        sum_wide;
    logic signed [31:0]        sum_new;
    logic signed [33:0]        quo_raw;
    logic signed [34:0]        pwr_wide;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign tick_next   = r_tick + 1'b1;
    assign close       = (tick_next >= WINDOW_END);
    assign cnt_sel     = r_wheel ? cnt_r : cnt_l;
    assign cnt_l_ext   = CEXT_W'(cnt_l);
    assign cnt_r_ext   = CEXT_W'(cnt_r);

    // The result register is loaded once the previous result has been taken,
    // so a window can finish while the consumer stalls.
    assign load = (r_state == S_DONE) && (!r_out_valid || i_ready);

    dwsp_edge #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_edge_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_level (i_enc_left),
        .i_clear (load),
        .o_count (cnt_l)
    );

    dwsp_edge #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_edge_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (accept),
        .i_level (i_enc_right),
        .i_clear (load),
        .o_count (cnt_r)
    );

    dwsp_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    // Datapath pieces that only the sequencer below consumes.
    always_comb begin
        // Target minus measured speed; the speed product never exceeds 32 bits.
        spd_err = $signed({19'd0, r_target}) - $signed(prod[33:0]);
        if (spd_err > 34'sd32767) begin
            err_sat = 16'sh7FFF;
        end else if (spd_err < -34'sd32768) begin
            err_sat = -16'sh8000;
        end else begin
            err_sat = spd_err[15:0];
        end

        // Integral: accumulate with 32 bit saturation inside the zone, else clear.
        sum_wide = {r_sum[r_wheel][31], r_sum[r_wheel]} + 33'(r_err);
        if (sum_wide[32] != sum_wide[31]) begin
            sum_new = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sum_new = sum_wide[31:0];
        end
        if (!((r_err < r_zone) && (r_err != '0))) begin
            sum_new = '0;
        end
        if (sum_new > $signed({1'b0, r_cap})) begin
            sum_new = $signed({1'b0, r_cap});
        end

        // Drop the fraction, rounding toward zero for negative totals.
        quo_raw = r_acc[PROD_W-1:16];
        if (r_acc[PROD_W-1] && (r_acc[15:0] != '0)) begin
            quo_raw = quo_raw + 34'sd1;
        end

        pwr_wide = $signed({25'd0, r_pwr[r_wheel]}) + 35'(r_quo);
    end

    // Sequencer and register updates.
    always_comb begin
        n_state     = r_state;
        n_wheel     = r_wheel;
        n_tick      = r_tick;
        n_sum       = r_sum;
        n_last      = r_last;
        n_pwr       = r_pwr;
        n_out_valid = r_out_valid;
        n_err       = r_err;
        n_diff      = r_diff;
        n_acc       = r_acc;
        n_quo       = r_quo;
        n_target    = r_target;
        n_gain_p    = r_gain_p;
        n_gain_i    = r_gain_i;
        n_gain_d    = r_gain_d;
        n_zone      = r_zone;
        n_cap       = r_cap;
        n_max       = r_max;
        mul_req     = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (close) begin
                        n_tick  = '0;
                        n_wheel = 1'b0;
                        n_state = S_SPEED;
                    end else begin
                        n_tick = tick_next;
                    end
                end
            end
            S_SPEED: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(cnt_sel);
                mul_req.b  = MUL_B_W'(SPEED_PER_COUNT);
                n_state    = S_ERR;
            end
            S_ERR: begin
                n_err           = err_sat;
                n_diff          = 17'(err_sat) - 17'(r_last[r_wheel]);
                n_last[r_wheel] = err_sat;
                n_state         = S_SUM;
            end
            S_SUM: begin
                n_sum[r_wheel] = sum_new;
                n_state        = S_MP;
            end
            S_MP: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(r_err);
                mul_req.b  = $signed({1'b0, r_gain_p});
                n_state    = S_MI;
            end
            S_MI: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(r_sum[r_wheel]);
                mul_req.b  = $signed({1'b0, r_gain_i});
                n_acc      = prod;
                n_state    = S_MD;
            end
            S_MD: begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_W'(r_diff);
                mul_req.b  = $signed({1'b0, r_gain_d});
                n_acc      = r_acc + prod;
                n_state    = S_ADD;
            end
            S_ADD: begin
                n_acc   = r_acc + prod;
                n_state = S_TRUNC;
            end
            S_TRUNC: begin
                n_quo   = quo_raw;
                n_state = S_PWR;
            end
            S_PWR: begin
                if (pwr_wide < 35'sd0) begin
                    n_pwr[r_wheel] = '0;
                end else if (pwr_wide > $signed({25'd0, r_max})) begin
                    n_pwr[r_wheel] = r_max;
                end else begin
                    n_pwr[r_wheel] = pwr_wide[POWER_W-1:0];
                end
                if (r_wheel) begin
                    n_state = S_DONE;
                end else begin
                    n_wheel = 1'b1;
                    n_state = S_SPEED;
                end
            end
            S_DONE: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_wheel     = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Configuration writes; unknown indexes fall through untouched.
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_TARGET_SPEED:  n_target = i_cfg_data[14:0];
                REG_GAIN_P:        n_gain_p = i_cfg_data[15:0];
                REG_GAIN_I:        n_gain_i = i_cfg_data[15:0];
                REG_GAIN_D:        n_gain_d = i_cfg_data[15:0];
                REG_INTEGRAL_ZONE: n_zone   = $signed(i_cfg_data[15:0]);
                REG_INTEGRAL_CAP:  n_cap    = i_cfg_data[30:0];
                REG_MAX_POWER:     n_max    = i_cfg_data[POWER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wheel     <= 1'b0;
            r_tick      <= '0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_last[0]   <= '0;
            r_last[1]   <= '0;
            r_pwr[0]    <= '0;
            r_pwr[1]    <= '0;
            r_out_valid <= 1'b0;
            r_target    <= 15'd0;
            r_gain_p    <= 16'd4352;
            r_gain_i    <= 16'd320;
            r_gain_d    <= 16'd166;
            r_zone      <= 16'sd2560;
            r_cap       <= 31'd2048;
            r_max       <= 10'd900;
        end else begin
            r_state     <= n_state;
            r_wheel     <= n_wheel;
            r_tick      <= n_tick;
            r_sum       <= n_sum;
            r_last      <= n_last;
            r_pwr       <= n_pwr;
            r_out_valid <= n_out_valid;
            r_target    <= n_target;
            r_gain_p    <= n_gain_p;
            r_gain_i    <= n_gain_i;
            r_gain_d    <= n_gain_d;
            r_zone      <= n_zone;
            r_cap       <= n_cap;
            r_max       <= n_max;
        end
    end

    // Working and result registers carry payload only and need no reset.
    always_ff @(posedge i_clk) begin
        r_err  <= n_err;
        r_diff <= n_diff;
        r_acc  <= n_acc;
        r_quo  <= n_quo;
        if (load) begin
            r_out_pwr_l <= r_pwr[0];
            r_out_pwr_r <= r_pwr[1];
            r_out_cnt_l <= cnt_l_ext[OUT_CNT_W-1:0];
            r_out_cnt_r <= cnt_r_ext[OUT_CNT_W-1:0];
            r_out_err_l <= r_last[0];
            r_out_err_r <= r_last[1];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_power_left  = r_out_pwr_l;
    assign o_power_right = r_out_pwr_r;
    assign o_count_left  = r_out_cnt_l;
    assign o_count_right = r_out_cnt_r;
    assign o_error_left  = r_out_err_l;
    assign o_error_right = r_out_err_r;

`ifndef NO_ASSERTIONS
    // A tick that does not close the window leaves the block ready again.
    a_quick_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !close) |=> o_ready)
        else $error("block stalled after a tick inside the window");

    // Both wheels are processed before the result is loaded.
    a_done_wheel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> r_wheel)
        else $error("result step reached before the right wheel was done");

    // A new result only ever comes from the load step.
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result valid raised outside the load step");

    // Edge counts start the next window from zero.
    a_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> ((cnt_l == '0) && (cnt_r == '0)))
        else $error("edge counts not cleared after a window closed");
`endif

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for dual_wheel_speed_pid
// Drives encoder ticks and register writes through valid/ready channels,
// predicts every closed control window in a behavioral model of both wheel
// loops, and compares each result transaction field by field.
// ----------------------------------------------------------------------------
module tb;
    import dwsp_pkg::*;

    // Block parameters; the predictor uses the same values.
    localparam int WINDOW_TICKS    = 50;
    localparam int SPEED_PER_COUNT = 71;
    localparam int COUNT_WIDTH     = 12;

    // Register values after reset.
    localparam logic [14:0]        DEF_TARGET = 15'd0;
    localparam logic [15:0]        DEF_GAIN_P = 16'd4352;
    localparam logic [15:0]        DEF_GAIN_I = 16'd320;
    localparam logic [15:0]        DEF_GAIN_D = 16'd166;
    localparam logic signed [15:0] DEF_ZONE   = 16'sd2560;
    localparam logic [30:0]        DEF_CAP    = 31'd2048;
    localparam logic [9:0]         DEF_MAXPWR = 10'd900;

    // Indexes past the last register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_MAX_POWER + 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX   = '1;

    localparam int WHEEL_LEFT  = 0;
    localparam int WHEEL_RIGHT = 1;

    // Passed as an edge count to send_window: hold the line high all window.
    localparam int LEVEL_HIGH = -1;

    localparam int  HALF_PERIOD    = 6;
    localparam int  MAX_GAP        = 16;
    // Covers the busy sequence of a closing window, with a margin.
    localparam int  SETTLE_CYCLES  = 40;
    localparam int  LONG_HOLD      = 600;
    localparam int  RANDOM_WINDOWS = 40;
    localparam int  MAX_REPORTS    = 10;
    localparam longint LIMIT_CYCLES = 400000;

    localparam logic [COUNT_WIDTH-1:0] EDGE_MAX = '1;

    typedef struct {
        logic [POWER_W-1:0]       power_left;
        logic [POWER_W-1:0]       power_right;
        logic [OUT_CNT_W-1:0]     count_left;
        logic [OUT_CNT_W-1:0]     count_right;
        logic signed [ERR_W-1:0]  error_left;
        logic signed [ERR_W-1:0]  error_right;
    } wheel_result_t;

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_enc_right;
    logic                  i_enc_left;
    logic                  o_valid;
    logic                  i_ready;
    logic [POWER_W-1:0]    o_power_left;
    logic [POWER_W-1:0]    o_power_right;
    logic [OUT_CNT_W-1:0]  o_count_left;
    logic [OUT_CNT_W-1:0]  o_count_right;
    logic signed [ERR_W-1:0] o_error_left;
    logic signed [ERR_W-1:0] o_error_right;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dual_wheel_speed_pid #(
        .WINDOW_TICKS    (WINDOW_TICKS),
        .SPEED_PER_COUNT (SPEED_PER_COUNT),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_enc_right   (i_enc_right),
        .i_enc_left    (i_enc_left),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_power_left  (o_power_left),
        .o_power_right (o_power_right),
        .o_count_left  (o_count_left),
        .o_count_right (o_count_right),
        .o_error_left  (o_error_left),
        .o_error_right (o_error_right),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Shared run state
    // ------------------------------------------------------------------------
    wheel_result_t expected_results[$];
    int     check_errors    = 0;
    int     windows_checked = 0;
    int     ticks_sent      = 0;
    int     reg_writes      = 0;
    int     random_windows  = 0;
    longint cycle_count     = 0;
    // Set by the tests: no_idle removes all gaps on both sides, and a nonzero
    // hold_cycles makes the result sink refuse transactions for that long.
    bit     no_idle         = 1'b0;
    int     hold_cycles     = 0;

    // ------------------------------------------------------------------------
    // Predictor: register copies and loop state of both wheels.
    // Index 0 of every array is the left wheel, index 1 the right wheel.
    // ------------------------------------------------------------------------
    logic [14:0]             reg_target;
    logic [15:0]             reg_gain_p;
    logic [15:0]             reg_gain_i;
    logic [15:0]             reg_gain_d;
    logic signed [15:0]      reg_zone;
    logic [30:0]             reg_cap;
    logic [9:0]              reg_max_power;

    logic [TICK_W-1:0]       tick_cnt;
    logic                    prev_lvl[2];
    logic [COUNT_WIDTH-1:0]  edge_cnt[2];
    logic signed [31:0]      err_sum[2];
    logic signed [ERR_W-1:0] last_err[2];
    logic [POWER_W-1:0]      power_acc[2];

    function automatic void reset_predictor();
        reg_target    = DEF_TARGET;
        reg_gain_p    = DEF_GAIN_P;
        reg_gain_i    = DEF_GAIN_I;
        reg_gain_d    = DEF_GAIN_D;
        reg_zone      = DEF_ZONE;
        reg_cap       = DEF_CAP;
        reg_max_power = DEF_MAXPWR;
        tick_cnt      = '0;
        for (int w = 0; w < 2; w++) begin
            prev_lvl[w]  = 1'b0;
            edge_cnt[w]  = '0;
            err_sum[w]   = '0;
            last_err[w]  = '0;
            power_acc[w] = '0;
        end
    endfunction

    // Only the low bits of each register are kept; unknown indexes are dropped.
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TARGET_SPEED:  reg_target    = data[14:0];
            REG_GAIN_P:        reg_gain_p    = data[15:0];
            REG_GAIN_I:        reg_gain_i    = data[15:0];
            REG_GAIN_D:        reg_gain_d    = data[15:0];
            REG_INTEGRAL_ZONE: reg_zone      = data[15:0];
            REG_INTEGRAL_CAP:  reg_cap       = data[30:0];
            REG_MAX_POWER:     reg_max_power = data[9:0];
            default: ;
        endcase
    endfunction

    // A rising edge is a low level followed by a high one; the count sticks
    // at its maximum instead of wrapping.
    function automatic void count_edge(input int w, input logic lvl);
        if (!prev_lvl[w] && lvl && edge_cnt[w] != EDGE_MAX)
            edge_cnt[w] = edge_cnt[w] + 1'b1;
        prev_lvl[w] = lvl;
    endfunction

    // Closes the window of one wheel: speed error, integral sum, PID term and
    // the clamped power accumulator. Returns the saturated error.
    function automatic logic signed [ERR_W-1:0] close_wheel(input int w);
        longint speed;
        longint err;
        longint sum;
        longint total;
        longint pwr;
        speed = longint'(edge_cnt[w]) * SPEED_PER_COUNT;
        err   = longint'(reg_target) - speed;
        if (err > 32767)
            err = 32767;
        else if (err < -32768)
            err = -32768;

        // Integrate only inside the zone and on a nonzero error.
        if (err < longint'(reg_zone) && err != 0) begin
            sum = longint'(err_sum[w]) + err;
            if (sum > 64'sd2147483647)
                sum = 64'sd2147483647;
            else if (sum < -64'sd2147483648)
                sum = -64'sd2147483648;
        end else begin
            sum = 0;
        end
        if (sum > longint'(reg_cap))
            sum = longint'(reg_cap);
        err_sum[w] = sum[31:0];

        // Q16.16 sum of the three terms; division truncates toward zero.
        total = err * longint'(reg_gain_p) + sum * longint'(reg_gain_i)
              + (err - longint'(last_err[w])) * longint'(reg_gain_d);
        last_err[w] = err[ERR_W-1:0];

        pwr = longint'(power_acc[w]) + total / 65536;
        if (pwr > longint'(reg_max_power))
            pwr = longint'(reg_max_power);
        if (pwr < 0)
            pwr = 0;
        power_acc[w] = pwr[POWER_W-1:0];
        return err[ERR_W-1:0];
    endfunction

    // Advances the model by one accepted tick and queues the window result
    // when the tick closes a window.
    function automatic void predict_tick(input logic enc_r, input logic enc_l);
        wheel_result_t res;
        count_edge(WHEEL_RIGHT, enc_r);
        count_edge(WHEEL_LEFT, enc_l);
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt < WINDOW_TICKS)
            return;
        tick_cnt = '0;
        res.error_left  = close_wheel(WHEEL_LEFT);
        res.error_right = close_wheel(WHEEL_RIGHT);
        res.power_left  = power_acc[WHEEL_LEFT];
        res.power_right = power_acc[WHEEL_RIGHT];
        res.count_left  = edge_cnt[WHEEL_LEFT][OUT_CNT_W-1:0];
        res.count_right = edge_cnt[WHEEL_RIGHT][OUT_CNT_W-1:0];
        edge_cnt[WHEEL_LEFT]  = '0;
        edge_cnt[WHEEL_RIGHT] = '0;
        expected_results.push_back(res);
    endfunction

    // ------------------------------------------------------------------------
    // Drivers. All of them are entered and left on a falling clock edge.
    // ------------------------------------------------------------------------
    function automatic int draw_gap();
        if (no_idle)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Offers one tick after a random gap and waits for its transaction.
    // Valid is left high on return so that a back-to-back tick keeps it up;
    // settle() drops it when the stream pauses.
    task automatic send_tick(input logic enc_r, input logic enc_l);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_enc_right <= enc_r;
        i_enc_left  <= enc_l;
        do @(posedge i_clk); while (!o_ready);
        predict_tick(enc_r, enc_l);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // One register write transaction; valid is dropped again before the task returns.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_all_regs(input logic [CFG_DATA_W-1:0] target,
                                  input logic [CFG_DATA_W-1:0] gp,
                                  input logic [CFG_DATA_W-1:0] gi,
                                  input logic [CFG_DATA_W-1:0] gd,
                                  input logic [CFG_DATA_W-1:0] zone,
                                  input logic [CFG_DATA_W-1:0] cap,
                                  input logic [CFG_DATA_W-1:0] max_pwr);
        write_reg(REG_TARGET_SPEED, target);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_INTEGRAL_ZONE, zone);
        write_reg(REG_INTEGRAL_CAP, cap);
        write_reg(REG_MAX_POWER, max_pwr);
    endtask

    // Stops the tick stream, waits for every outstanding window result, then
    // lets the block finish any tick still in flight so that registers can
    // be written safely.
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One full window with a given number of clean pulses per wheel. Pulses
    // sit on odd ticks, so 25 pulses put the last rising edge on the closing
    // tick. LEVEL_HIGH holds the line high for the whole window.
    task automatic send_window(input int n_left, input int n_right);
        logic lv_l;
        logic lv_r;
        for (int t = 0; t < WINDOW_TICKS; t++) begin
            lv_l = (n_left == LEVEL_HIGH) ? 1'b1 : ((t % 2 == 1) && (t / 2 < n_left));
            lv_r = (n_right == LEVEL_HIGH) ? 1'b1 : ((t % 2 == 1) && (t / 2 < n_right));
            send_tick(lv_r, lv_l);
        end
    endtask

    // One window of random content per wheel: mostly square waves of random
    // period and phase, some constant lines and some pure noise.
    task automatic send_random_window();
        int   style[2];
        int   half_per[2];
        int   phase[2];
        logic steady[2];
        logic lv[2];
        for (int w = 0; w < 2; w++) begin
            style[w]    = $urandom_range(0, 9);
            half_per[w] = $urandom_range(1, 12);
            phase[w]    = $urandom_range(0, 23);
            steady[w]   = $urandom_range(0, 1);
        end
        for (int t = 0; t < WINDOW_TICKS; t++) begin
            for (int w = 0; w < 2; w++) begin
                if (style[w] < 7)
                    lv[w] = ((t + phase[w]) / half_per[w]) % 2;
                else if (style[w] < 8)
                    lv[w] = steady[w];
                else
                    lv[w] = $urandom_range(0, 1);
            end
            send_tick(lv[WHEEL_RIGHT], lv[WHEEL_LEFT]);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stall before each transaction, plus the long
    // hold-off that the back-pressure test asks for, counted here in cycles.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (hold_cycles) @(negedge i_clk);
                hold_cycles = 0;
            end
            stall = draw_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every result transaction against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        wheel_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                check_errors++;
                if (check_errors <= MAX_REPORTS)
                    $display("Result with no window pending at cycle %0d", cycle_count);
            end else begin
                want = expected_results.pop_front();
                windows_checked++;
                if (want.power_left  !== o_power_left  ||
                    want.power_right !== o_power_right ||
                    want.count_left  !== o_count_left  ||
                    want.count_right !== o_count_right ||
                    want.error_left  !== o_error_left  ||
                    want.error_right !== o_error_right) begin
                    check_errors++;
                    if (check_errors <= MAX_REPORTS) begin
                        $display("Window %0d mismatch (L/R): power %0d/%0d count %0d/%0d",
                                 windows_checked, want.power_left, want.power_right,
                                 want.count_left, want.count_right);
                        $display("  expected error %0d/%0d", want.error_left,
                                 want.error_right);
                        $display("  actual power %0d/%0d count %0d/%0d error %0d/%0d",
                                 o_power_left, o_power_right, o_count_left,
                                 o_count_right, o_error_left, o_error_right);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout at cycle %0d with %0d windows outstanding",
                     cycle_count, expected_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values of all registers. Covers a window without edges (zero
    // error clears the sum), the most edges a window can hold with the last
    // one on the closing tick, and a line that stays high across the window
    // boundary, which must not count as a new edge.
    task automatic test_default_registers();
        send_window(0, 0);
        send_window(25, 25);
        send_window(LEVEL_HIGH, LEVEL_HIGH);
        send_window(3, 7);
        settle();
    endtask

    // All-ones writes leave only the register width; writes to unknown
    // indexes must be ignored. Then every register at zero.
    task automatic test_register_extremes();
        write_all_regs('1, '1, '1, '1, '1, '1, '1);
        write_reg(REG_FIRST_UNUSED, '0);
        write_reg(REG_LAST_INDEX, '0);
        send_window(0, LEVEL_HIGH);
        send_window(25, 25);
        settle();
        write_all_regs('0, '0, '0, '0, '0, '0, '0);
        send_window(1, 0);
        send_window(0, 25);
        settle();
    endtask

    // Integration window: positive errors above the zone clear the sum, both
    // at zone 71 and at zone 72, a negative error integrates downward, and the
    // last window integrates on the left while the right is cleared.
    task automatic test_integral_zone();
        write_all_regs(32'd710, 32'd0, 32'd256, 32'd0, 32'd71, 32'd100, 32'd1023);
        send_window(4, 4);
        settle();
        write_reg(REG_INTEGRAL_ZONE, 32'd72);
        send_window(4, 4);
        send_window(4, 4);
        send_window(5, 5);
        send_window(12, 12);
        send_window(12, 4);
        settle();
    endtask

    // Power driven into the upper clamp, then an upper limit below the
    // accumulator, then down into zero.
    task automatic test_power_clamp();
        write_all_regs(32'd32767, 32'd65535, 32'd0, 32'd128, 32'd0, 32'd0, 32'd1023);
        send_window(0, 2);
        settle();
        write_reg(REG_MAX_POWER, 32'd5);
        send_window(0, 0);
        settle();
        write_reg(REG_TARGET_SPEED, 32'd0);
        write_reg(REG_MAX_POWER, 32'd1023);
        send_window(25, 20);
        settle();
    endtask

    // Ticks keep coming back to back while the sink refuses results for a
    // long stretch, so a finished window waits and the next one stalls the
    // tick input.
    task automatic test_output_backpressure();
        write_all_regs(32'd900, 32'd300, 32'd40, 32'd20, 32'd2560, 32'd5000, 32'd1023);
        no_idle = 1'b1;
        send_random_window();
        hold_cycles = LONG_HOLD;
        repeat (3) send_random_window();
        no_idle = 1'b0;
        settle();
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_gain();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'd65535;
            2, 3:    return $urandom_range(0, 65535);
            9:       return $urandom();
            default: return $urandom_range(0, 512);
        endcase
    endfunction

    task automatic randomize_registers();
        logic [CFG_DATA_W-1:0] target;
        logic [CFG_DATA_W-1:0] zone;
        logic [CFG_DATA_W-1:0] cap;
        logic [CFG_DATA_W-1:0] max_pwr;
        case ($urandom_range(0, 7))
            0:       target = '0;
            1:       target = 32'd32767;
            2:       target = $urandom();
            3:       target = $urandom_range(0, 32767);
            default: target = $urandom_range(0, 2000);
        endcase
        case ($urandom_range(0, 5))
            0:       zone = 32'h0000_8000;
            1:       zone = 32'h0000_7FFF;
            2:       zone = $urandom();
            default: zone = $urandom_range(0, 5000) - 2000;
        endcase
        case ($urandom_range(0, 4))
            0:       cap = '0;
            1:       cap = $urandom() & 32'h7FFF_FFFF;
            2:       cap = $urandom();
            default: cap = $urandom_range(0, 5000);
        endcase
        case ($urandom_range(0, 5))
            0:       max_pwr = '0;
            1:       max_pwr = 32'd1023;
            default: max_pwr = $urandom_range(0, 1023);
        endcase
        write_all_regs(target, random_gain(), random_gain(), random_gain(),
                       zone, cap, max_pwr);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_FIRST_UNUSED + $urandom_range(0, 248), $urandom());
    endtask

    // Random register sets, each followed by a few windows of random
    // encoder traffic; some phases run without any gaps on either side.
    task automatic test_random_traffic();
        while (random_windows < RANDOM_WINDOWS) begin
            randomize_registers();
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 6)) begin
                send_random_window();
                random_windows++;
            end
            no_idle = 1'b0;
            settle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_enc_right = 1'b0;
        i_enc_left  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        reset_predictor();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_registers();
        test_register_extremes();
        test_integral_zone();
        test_power_clamp();
        test_output_backpressure();
        test_random_traffic();

        // settle() has drained the queue and waited out the block's latency.
        settle();
        if (expected_results.size() != 0)
            check_errors++;

        $display("Run covered %0d ticks, %0d checked windows and %0d register writes,",
                 ticks_sent, windows_checked, reg_writes);
        $display("with register extremes, integral zone and cap, power clamps, "
                 + "output back-pressure and %0d random windows.", random_windows);
        if (check_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches found", check_errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
